/* rtl/core/nss_pkg.sv */
// nss_pkg: shared widths, codes and handshake structs of the note step sequencer.
// Used by every module under rtl/core; depends on nothing.
package nss_pkg;

  localparam int STEP_DEPTH_DEF = 64;

  localparam int RATE_W   = 18;
  localparam int UNIT_W   = 16;
  localparam int LEN_W    = 16;
  localparam int PITCH_W  = 24;
  localparam int VEL_W    = 8;
  localparam int POS_W    = 7;
  localparam int VOICE_W  = 5;
  localparam int CNT_W    = 32;
  localparam int REM_W    = 10;
  localparam int PROD_W   = RATE_W + UNIT_W + LEN_W;
  localparam int ENTRY_W  = PITCH_W + VEL_W + LEN_W;
  localparam int MS_DIV   = 1000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // operation codes
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // event codes
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_ON   = 2'd1;
  localparam logic [1:0] EV_OFF  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_OVR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_EN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VOICE       = 3'd5;

  typedef struct packed {
    logic              start;
    logic [RATE_W-1:0] rate;
    logic [UNIT_W-1:0] unit;
    logic [LEN_W-1:0]  len;
    logic [REM_W-1:0]  rem;
  } nss_dur_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
    logic [REM_W-1:0] rem;
  } nss_dur_rsp_t;

endpackage

/* rtl/core/nss_ram.sv */
// nss_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nss_pkg for default sizes only.
module nss_ram
  import nss_pkg::*;
#(
  parameter int WIDTH = ENTRY_W,
  parameter int DEPTH = STEP_DEPTH_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/nss_dur_unit.sv */
// nss_dur_unit: bit-serial step duration unit, rate*unit*len + rem, then /1000.
// Shift-add multiply one bit a cycle, restoring divide one bit a cycle. Uses nss_pkg.
module nss_dur_unit
  import nss_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  nss_dur_req_t req,
  output nss_dur_rsp_t rsp
);

  typedef enum logic [2:0] {D_IDLE, D_MUL1, D_MUL2, D_DIV, D_DONE} dur_state_t;

  localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(MS_DIV);

  dur_state_t        state_r;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] mcand_r;
  logic [RATE_W-1:0] mplier_r;
  logic [RATE_W-1:0] rate_r;
  logic [REM_W-1:0]  rem_r;
  logic [5:0]        cnt_r;

  logic [PROD_W-1:0] acc_add;
  logic [REM_W:0]    trial;
  logic              trial_ge;
  logic [REM_W-1:0]  rem_nxt;

  assign acc_add  = acc_r + (mplier_r[0] ? mcand_r : '0);
  assign trial    = {rem_r, acc_r[PROD_W-1]};
  assign trial_ge = (trial >= DIVISOR);
  assign rem_nxt  = trial_ge ? REM_W'(trial - DIVISOR) : trial[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (req.start) begin
            mcand_r  <= PROD_W'(req.unit);
            mplier_r <= RATE_W'(req.len);
            acc_r    <= '0;
            rate_r   <= req.rate;
            rem_r    <= req.rem;
            cnt_r    <= 6'(LEN_W - 1);
            state_r  <= D_MUL1;
          end
        end
        D_MUL1: begin
          if (cnt_r == '0) begin
            // unit*len done; multiply it by the rate, seeding the carried remainder
            mcand_r  <= acc_add;
            mplier_r <= rate_r;
            acc_r    <= PROD_W'(rem_r);
            cnt_r    <= 6'(RATE_W - 1);
            state_r  <= D_MUL2;
          end else begin
            acc_r    <= acc_add;
            mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
            mplier_r <= {1'b0, mplier_r[RATE_W-1:1]};
            cnt_r    <= cnt_r - 6'd1;
          end
        end
        D_MUL2: begin
          acc_r    <= acc_add;
          mcand_r  <= {mcand_r[PROD_W-2:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[RATE_W-1:1]};
          if (cnt_r == '0) begin
            rem_r   <= '0;
            cnt_r   <= 6'(PROD_W - 1);
            state_r <= D_DIV;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        D_DIV: begin
          // quotient bits shift in where dividend bits shift out
          acc_r <= {acc_r[PROD_W-2:0], trial_ge};
          rem_r <= rem_nxt;
          if (cnt_r == '0) begin
            state_r <= D_DONE;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        D_DONE: begin
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    rsp.done = (state_r == D_DONE);
    rsp.rem  = rem_r;
    if (|acc_r[PROD_W-1:CNT_W]) begin
      rsp.count = '1;
    end else if (acc_r == '0) begin
      rsp.count = CNT_W'(1);
    end else begin
      rsp.count = acc_r[CNT_W-1:0];
    end
  end

endmodule

/* rtl/core/note_step_sequencer_top.sv */
// note_step_sequencer_top: step table player driven by sample ticks.
// Uses nss_pkg, nss_ram (step table) and nss_dur_unit (countdown reload).
//
//  channel | ports                              | direction | payload
//  input   | in_tvalid in_tready in_tdata/tuser | slave     | one operation
//  result  | out_tvalid out_tready out_tdata/tuser | master | one event per operation
//  config  | cfg_valid cfg_ready cfg_index/data | slave     | register write, always ready
//
// One item at a time. A tick that loads a new step goes from its transfer to the next input
// transfer through the table read (S_RD, S_LD), the serial multiplies (unit by length, then by
// rate), the serial divide by 1000, the done state and the result register, then the transfer.
// Other operations go from the input transfer straight to the result register.
// Reset (rst_n low, synchronous) restores register defaults and player state; the
// step table keeps its contents. A stalled result holds the next result, and the input.
module note_step_sequencer_top
  import nss_pkg::*;
#(
  parameter int STEP_DEPTH = STEP_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // step_addr[5:0], step_pitch[29:6], step_velocity[37:30], step_length[53:38],
  // keep_remainder[54], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // voice[3:0], pitch[27:4], velocity[35:28], finished[36], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata,
  // event_res[1:0]
  output logic [1:0]            out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW   = (STEP_DEPTH > 1) ? $clog2(STEP_DEPTH) : 1;
  localparam int XW   = (AW + 1 > POS_W) ? AW + 1 : POS_W;
  localparam int CLIP = (STEP_DEPTH > 127) ? 127 : STEP_DEPTH;
  localparam logic [POS_W-1:0] DEPTH_CLIP = POS_W'(CLIP);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_LD, S_CALC, S_RES} seq_state_t;

  seq_state_t        state_r;
  logic [RATE_W-1:0] sample_rate_r;
  logic [UNIT_W-1:0] unit_ms_r;
  logic [UNIT_W-1:0] unit_ovr_r;
  logic [POS_W-1:0]  step_count_r;
  logic              loop_en_r;
  logic [VOICE_W-1:0] voice_r;

  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  samples_left_r;
  logic [REM_W-1:0]  ms_rem_r;
  logic              done_r;

  logic [1:0]         res_ev_r;
  logic [PITCH_W-1:0] res_pitch_r;
  logic [VEL_W-1:0]   res_vel_r;

  logic               out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic [1:0]         out_tuser_r;

  // input fields
  logic [5:0]         f_addr;
  logic [PITCH_W-1:0] f_pitch;
  logic [VEL_W-1:0]   f_vel;
  logic [LEN_W-1:0]   f_len;
  logic               f_keep;

  logic               in_xfer;
  logic               res_load;
  logic [POS_W-1:0]   count;
  logic               active;
  logic               addr_ok;
  logic [XW-1:0]      waddr_x;
  logic [XW-1:0]      raddr_x;
  logic [ENTRY_W-1:0] rdata;
  logic [PITCH_W-1:0] rd_pitch;
  logic [VEL_W-1:0]   rd_vel;
  logic [LEN_W-1:0]   rd_len;

  nss_dur_req_t dur_req;
  nss_dur_rsp_t dur_rsp;

  assign f_addr  = in_tdata[5:0];
  assign f_pitch = in_tdata[29:6];
  assign f_vel   = in_tdata[37:30];
  assign f_len   = in_tdata[53:38];
  assign f_keep  = in_tdata[54];

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign res_load   = (state_r == S_RES) && (!out_tvalid_r || out_tready);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign count   = (step_count_r > DEPTH_CLIP) ? DEPTH_CLIP : step_count_r;
  assign active  = (count != '0) && !voice_r[VOICE_W-1] && !done_r;
  assign waddr_x = XW'(f_addr);
  assign raddr_x = XW'(pos_r);
  assign addr_ok = (waddr_x < XW'(STEP_DEPTH));

  assign rd_pitch = rdata[PITCH_W-1:0];
  assign rd_vel   = rdata[PITCH_W+VEL_W-1:PITCH_W];
  assign rd_len   = rdata[ENTRY_W-1:PITCH_W+VEL_W];

  nss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STEP_DEPTH)
  ) u_step_ram (
    .clk   (clk),
    .we    (in_xfer && (in_tuser == OP_WRITE) && addr_ok),
    .waddr (waddr_x[AW-1:0]),
    .wdata ({f_len, f_vel, f_pitch}),
    .raddr (raddr_x[AW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    dur_req.start = (state_r == S_LD);
    dur_req.rate  = sample_rate_r;
    dur_req.unit  = (unit_ovr_r != '0) ? unit_ovr_r : unit_ms_r;
    dur_req.len   = rd_len;
    dur_req.rem   = ms_rem_r;
  end

  nss_dur_unit u_dur (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dur_req),
    .rsp   (dur_rsp)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= RATE_W'(48000);
      unit_ms_r     <= UNIT_W'(100);
      unit_ovr_r    <= '0;
      step_count_r  <= '0;
      loop_en_r     <= 1'b0;
      voice_r       <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate_r <= cfg_data[RATE_W-1:0];
        REG_UNIT_MS:     unit_ms_r     <= cfg_data[UNIT_W-1:0];
        REG_UNIT_OVR:    unit_ovr_r    <= cfg_data[UNIT_W-1:0];
        REG_STEP_COUNT:  step_count_r  <= cfg_data[POS_W-1:0];
        REG_LOOP_EN:     loop_en_r     <= cfg_data[0];
        REG_VOICE:       voice_r       <= cfg_data[VOICE_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      pos_r          <= '0;
      samples_left_r <= '0;
      ms_rem_r       <= '0;
      done_r         <= 1'b0;
      out_tvalid_r   <= 1'b0;
    end else begin
      if (out_tready && !res_load) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            res_pitch_r <= '0;
            res_vel_r   <= '0;
            case (in_tuser)
              OP_TICK: begin
                if (active && (samples_left_r == '0)) begin
                  if ((pos_r >= count) && !loop_en_r) begin
                    done_r   <= 1'b1;
                    res_ev_r <= EV_OFF;
                    state_r  <= S_RES;
                  end else begin
                    if (pos_r >= count) begin
                      pos_r <= '0;
                    end
                    state_r <= S_RD;
                  end
                end else begin
                  if (active) begin
                    samples_left_r <= samples_left_r - CNT_W'(1);
                  end
                  res_ev_r <= EV_NONE;
                  state_r  <= S_RES;
                end
              end
              OP_RESTART: begin
                samples_left_r <= '0;
                pos_r          <= '0;
                done_r         <= 1'b0;
                if (!f_keep) begin
                  ms_rem_r <= '0;
                end
                res_ev_r <= (!f_keep && !voice_r[VOICE_W-1]) ? EV_OFF : EV_NONE;
                state_r  <= S_RES;
              end
              default: begin
                res_ev_r <= EV_NONE;
                state_r  <= S_RES;
              end
            endcase
          end
        end
        S_RD: begin
          state_r <= S_LD;
        end
        S_LD: begin
          // duration unit starts this cycle on the length read from the table
          res_pitch_r <= rd_pitch;
          res_vel_r   <= rd_vel;
          state_r     <= S_CALC;
        end
        S_CALC: begin
          if (dur_rsp.done) begin
            // countdown already counts this tick
            samples_left_r <= dur_rsp.count - CNT_W'(1);
            ms_rem_r       <= dur_rsp.rem;
            pos_r          <= pos_r + POS_W'(1);
            if ((res_pitch_r != '0) && (res_vel_r != '0)) begin
              res_ev_r <= EV_ON;
            end else begin
              res_ev_r    <= EV_OFF;
              res_pitch_r <= '0;
              res_vel_r   <= '0;
            end
            state_r <= S_RES;
          end
        end
        S_RES: begin
          if (res_load) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= res_ev_r;
            out_tdata_r  <= {3'b000, done_r, res_vel_r, res_pitch_r,
                             (res_ev_r != EV_NONE) ? voice_r[3:0] : 4'd0};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_dur_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    dur_rsp.done |-> (state_r == S_CALC))
    else $error("duration unit finished outside of step load");

  a_done_stopped: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (samples_left_r == '0))
    else $error("finished pattern with a running countdown");

  a_note_on_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && (out_tuser_r == EV_ON)) |->
      ((out_tdata_r[27:4] != '0) && (out_tdata_r[35:28] != '0)))
    else $error("note on with zero pitch or velocity");

endmodule
